>>> src/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// shared constants and the cordic arctangent table for the euler block
// ----------------------------------------------------------------------------
package rme_pkg;

	localparam int TabLen = 24;
	localparam int ZW = 34;                         // q4.30 angle accumulator
	localparam logic signed [ZW-1:0] HalfPiQ30 = 34'sd1686629713;
	localparam int AngleLimit = 25736;
	localparam int AngleW = 16;

	localparam logic [0:0] RegThreshold = 1'b0;

	function automatic logic signed [ZW-1:0] atan_tab(input int unsigned i);
		logic signed [ZW-1:0] t;
		begin
			t = '0;
			case (i)
				0: t = 34'sh3243F6A8;
				1: t = 34'sh1DAC6705;
				2: t = 34'sh0FADBAFC;
				3: t = 34'sh07F56EA6;
				4: t = 34'sh03FEAB76;
				5: t = 34'sh01FFD55B;
				6: t = 34'sh00FFFAAA;
				7: t = 34'sh007FFF55;
				8: t = 34'sh003FFFEA;
				9: t = 34'sh001FFFFD;
				10: t = 34'sh000FFFFF;
				11: t = 34'sh0007FFFF;
				12: t = 34'sh0003FFFF;
				13: t = 34'sh0001FFFF;
				14: t = 34'sh0000FFFF;
				15: t = 34'sh00007FFF;
				16: t = 34'sh00003FFF;
				17: t = 34'sh00001FFF;
				18: t = 34'sh00000FFF;
				19: t = 34'sh000007FF;
				20: t = 34'sh000003FF;
				21: t = 34'sh000001FF;
				22: t = 34'sh000000FF;
				23: t = 34'sh0000007F;
				default: t = '0;
			endcase
			return t;
		end
	endfunction

endpackage

>>> src/rme_cordic.sv
// ----------------------------------------------------------------------------
// rme_cordic
// pipelined vectoring cordic, one stage per register, gives atan2 in q3.13
// ----------------------------------------------------------------------------
module rme_cordic #(
	parameter int DATA_WIDTH = 16,
	parameter int CORDIC_STAGES = 16,
	parameter int LAT = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic signed [DATA_WIDTH:0]       y_in,
	input  logic signed [DATA_WIDTH:0]       x_in,
	output logic signed [rme_pkg::AngleW-1:0] angle
);
	import rme_pkg::*;

	localparam int NS = (CORDIC_STAGES < TabLen) ? CORDIC_STAGES : TabLen;
	localparam int VW = DATA_WIDTH + 12;   // scaled by 256, plus growth

	logic signed [VW-1:0] x_s [0:NS];
	logic signed [VW-1:0] y_s [0:NS];
	logic signed [ZW-1:0] z_s [0:NS];
	logic                 zero_s [0:NS];
	logic signed [AngleW-1:0] res_s;
	logic signed [ZW-1:0] rnd;
	logic signed [ZW-1:0] shr;

	// pre-rotation stage into the right half plane
	always_ff @(posedge clk) begin
		logic signed [VW-1:0] xs, ys;
		xs = VW'(x_in) <<< 8;
		ys = VW'(y_in) <<< 8;
		zero_s[0] <= (x_in == '0) && (y_in == '0);
		if (xs < 0) begin
			if (ys >= 0) begin
				x_s[0] <= ys; y_s[0] <= -xs; z_s[0] <= HalfPiQ30;
			end else begin
				x_s[0] <= -ys; y_s[0] <= xs; z_s[0] <= -HalfPiQ30;
			end
		end else begin
			x_s[0] <= xs; y_s[0] <= ys; z_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_stage
		always_ff @(posedge clk) begin
			zero_s[i+1] <= zero_s[i];
			if (y_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_tab(i);
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_tab(i);
			end
		end
	end

	// round half up to q3.13 and clamp
	assign rnd = z_s[NS] + ZW'(65536);
	assign shr = rnd >>> 17;
	always_ff @(posedge clk) begin
		if (zero_s[NS])
			res_s <= '0;
		else if (shr > ZW'(AngleLimit))
			res_s <= AngleW'(AngleLimit);
		else if (shr < -ZW'(AngleLimit))
			res_s <= -AngleW'(AngleLimit);
		else
			res_s <= shr[AngleW-1:0];
	end

	// output delay to the common latency
	logic signed [AngleW-1:0] d_s [0:LAT];
	assign d_s[0] = res_s;
	for (genvar k = 0; k < LAT; k++) begin : g_dly
		always_ff @(posedge clk) d_s[k+1] <= d_s[k];
	end
	assign angle = d_s[LAT];

	logic unused_rst;
	assign unused_rst = arst_n;
endmodule

>>> src/rotation_matrix_to_euler_top.sv
// stages: square, sum, one isqrt root bit per stage, cordic pre-rotation, cordic stages,
// cordic rounding, output register; the cordic stage count is capped at 24
// throughput: one matrix a cycle, start accepted whenever busy is low; busy is tied low
// the receiver cannot stall; results appear one cycle each with done high
// reset: arst_n clears the valid pipe and sets singular_threshold to 1
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_top
// rotation matrix to z-y-x euler angles, pipelined isqrt feeding three cordics
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_top #(
	parameter int CORDIC_STAGES = 16,
	parameter int DATA_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [DATA_WIDTH-1:0] r00,
	input  logic signed [DATA_WIDTH-1:0] r10,
	input  logic signed [DATA_WIDTH-1:0] r11,
	input  logic signed [DATA_WIDTH-1:0] r12,
	input  logic signed [DATA_WIDTH-1:0] r20,
	input  logic signed [DATA_WIDTH-1:0] r21,
	input  logic signed [DATA_WIDTH-1:0] r22,
	output logic                         done,
	output logic signed [15:0]           angle_x,
	output logic signed [15:0]           angle_y,
	output logic signed [15:0]           angle_z,
	output logic                         singular,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [1:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import rme_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int SW = 2 * DW;           // square sum width
	localparam int RW = DW;               // root width
	localparam int NB = RW;               // root bits, one per stage
	localparam int NS = (CORDIC_STAGES < TabLen) ? CORDIC_STAGES : TabLen;
	localparam int CL = NS + 2;           // cordic latency
	localparam int PRE = 2 + NB;          // square, sum, isqrt stages
	localparam int TOT = PRE + CL;

	// ---- configuration port ----
	logic [14:0] thr_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 15'd1;
		end else if (psel && penable && pwrite && paddr == {1'b0, RegThreshold}) begin
			thr_q <= pwdata[14:0];
		end
	end
	assign prdata = (paddr == {1'b0, RegThreshold}) ? {17'd0, thr_q} : 32'd0;

	assign busy = 1'b0;

	// saturating negation
	function automatic logic signed [DW-1:0] neg_sat(input logic signed [DW-1:0] v);
		begin
			if (v == {1'b1, {(DW-1){1'b0}}})
				return {1'b0, {(DW-1){1'b1}}};
			return -v;
		end
	endfunction

	// ---- stage 1: squares ----
	logic [SW-1:0] sq0_s1, sq1_s1;
	logic signed [DW-1:0] m_s1 [0:6];
	logic [TOT:0] v_q;
	always_ff @(posedge clk) begin
		sq0_s1 <= SW'(r00) * SW'(r00);
		sq1_s1 <= SW'(r10) * SW'(r10);
		m_s1[0] <= r00; m_s1[1] <= r10; m_s1[2] <= r11; m_s1[3] <= r12;
		m_s1[4] <= r20; m_s1[5] <= r21; m_s1[6] <= r22;
	end
	// ---- stage 2: sum ----
	logic [SW:0] sum_s2;
	logic signed [DW-1:0] m_s2 [0:6];
	always_ff @(posedge clk) begin
		sum_s2 <= {1'b0, sq0_s1} + {1'b0, sq1_s1};
		m_s2 <= m_s1;
	end

	// ---- isqrt: one root bit per stage, restoring ----
	logic [SW+1:0] rem_p [0:NB];
	logic [RW:0]   root_p [0:NB];
	logic signed [DW-1:0] m_p [0:NB][0:6];
	assign rem_p[0] = {1'b0, sum_s2};
	assign root_p[0] = '0;
	assign m_p[0] = m_s2;
	for (genvar b = 0; b < NB; b++) begin : g_sqrt
		localparam int SH = 2 * (NB - 1 - b);
		logic [SW+1:0] trial;
		// (4 * root + 1) at the weight of the bit under test
		assign trial = (SW+2)'({root_p[b], 2'b01}) << SH;
		always_ff @(posedge clk) begin
			m_p[b+1] <= m_p[b];
			if (rem_p[b] >= trial) begin
				rem_p[b+1] <= rem_p[b] - trial;
				root_p[b+1] <= {root_p[b][RW-1:0], 1'b1};
			end else begin
				rem_p[b+1] <= rem_p[b];
				root_p[b+1] <= {root_p[b][RW-1:0], 1'b0};
			end
		end
	end

	// ---- branch select ----
	logic [RW:0] sy;
	logic        sing_c;
	logic signed [DW:0] ax_y, ax_x, ay_y, ay_x, az_y, az_x;
	assign sy = root_p[NB];
	assign sing_c = sy < (RW+1)'(thr_q);
	always_comb begin
		ay_y = (DW+1)'(neg_sat(m_p[NB][4]));
		ay_x = sy;
		if (!sing_c) begin
			ax_y = (DW+1)'(m_p[NB][5]); ax_x = (DW+1)'(m_p[NB][6]);
		end else begin
			ax_y = (DW+1)'(neg_sat(m_p[NB][3])); ax_x = (DW+1)'(m_p[NB][2]);
		end
		az_y = (DW+1)'(m_p[NB][1]); az_x = (DW+1)'(m_p[NB][0]);
	end

	logic sing_d [0:CL];
	assign sing_d[0] = sing_c;
	for (genvar k = 0; k < CL; k++) begin : g_sd
		always_ff @(posedge clk) sing_d[k+1] <= sing_d[k];
	end

	logic signed [15:0] ax_c, ay_c, az_c;
	rme_cordic #(.DATA_WIDTH(DW), .CORDIC_STAGES(NS), .LAT(0)) u_cx (
		.clk(clk), .arst_n(arst_n), .y_in(ax_y), .x_in(ax_x), .angle(ax_c));
	rme_cordic #(.DATA_WIDTH(DW), .CORDIC_STAGES(NS), .LAT(0)) u_cy (
		.clk(clk), .arst_n(arst_n), .y_in(ay_y), .x_in(ay_x), .angle(ay_c));
	rme_cordic #(.DATA_WIDTH(DW), .CORDIC_STAGES(NS), .LAT(0)) u_cz (
		.clk(clk), .arst_n(arst_n), .y_in(az_y), .x_in(az_x), .angle(az_c));

	// output register
	always_ff @(posedge clk) begin
		angle_x <= ax_c;
		angle_y <= ay_c;
		angle_z <= sing_d[CL] ? 16'sd0 : az_c;
		singular <= sing_d[CL];
	end

	// valid pipe, one bit per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else v_q <= {v_q[TOT-1:0], start};
	end
	assign done = v_q[TOT];
endmodule

>>> src/rme_checker.sv
// ----------------------------------------------------------------------------
// rme_checker
// port-level checks on the euler block results
// ----------------------------------------------------------------------------
module rme_props (
	input logic               clk,
	input logic               arst_n,
	input logic               done,
	input logic               singular,
	input logic signed [15:0] angle_x,
	input logic signed [15:0] angle_y,
	input logic signed [15:0] angle_z,
	input logic               busy
);
	a_z_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && singular |-> angle_z == 16'sd0) else $error("angle_z not zero");
	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> angle_x <= 16'sd25736 && angle_x >= -16'sd25736) else $error("x range");
	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> angle_y <= 16'sd25736 && angle_y >= -16'sd25736) else $error("y range");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised");
endmodule

bind rotation_matrix_to_euler_top rme_props u_chk (
	.clk(clk), .arst_n(arst_n), .done(done), .singular(singular),
	.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z), .busy(busy));

>>> tb/rme_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_checker
// predicts euler angles for each accepted matrix and compares the results
// ----------------------------------------------------------------------------
module rme_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [15:0] r00,
	input  logic signed [15:0] r10,
	input  logic signed [15:0] r11,
	input  logic signed [15:0] r12,
	input  logic signed [15:0] r20,
	input  logic signed [15:0] r21,
	input  logic signed [15:0] r22,
	input  logic               done,
	input  logic signed [15:0] angle_x,
	input  logic signed [15:0] angle_y,
	input  logic signed [15:0] angle_z,
	input  logic               singular,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 angles_seen,
	output int                 singular_seen,
	output int                 pending
);
	import rme_pkg::*;

	localparam int Stages = 16;

	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic               sing;
	} euler_t;

	euler_t      euler_q[$];
	logic [14:0] threshold;

	assign pending = euler_q.size();

	function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
		if (v == -16'sd32768) return 16'sd32767;
		return -v;
	endfunction

	function automatic logic [15:0] root_floor(input logic [31:0] n);
		logic [31:0] res;
		logic [31:0] b;
		logic [31:0] rem;
		res = 0;
		b = 32'h4000_0000;
		rem = n;
		while (b > rem) b = b >> 2;
		while (b != 0) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res[15:0];
	endfunction

	function automatic logic signed [15:0] arctan2(input longint yi, input longint xi);
		longint x, y, z, t, nx, ny, r;
		if (xi == 0 && yi == 0) return 0;
		x = xi * 256;
		y = yi * 256;
		z = 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = HalfPiQ30;
			end else begin
				x = -y; y = t; z = -HalfPiQ30;
			end
		end
		for (int i = 0; i < Stages && i < TabLen; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i); ny = y - (x >>> i); z = z + atan_tab(i);
			end else begin
				nx = x - (y >>> i); ny = y + (x >>> i); z = z - atan_tab(i);
			end
			x = nx;
			y = ny;
		end
		r = (z + (64'sd1 << 16)) >>> 17;
		if (r > AngleLimit) r = AngleLimit;
		if (r < -AngleLimit) r = -AngleLimit;
		return r[15:0];
	endfunction

	function automatic euler_t predict_euler(input logic signed [15:0] m00, m10, m11,
		m12, m20, m21, m22, input logic [14:0] thr);
		euler_t e;
		logic [31:0] sq;
		logic [15:0] sy;
		sq = 32'(longint'(m00) * m00 + longint'(m10) * m10);
		sy = root_floor(sq);
		e.sing = (sy < {1'b0, thr});
		e.ay = arctan2(neg_sat(m20), sy);
		if (!e.sing) begin
			e.ax = arctan2(m21, m22);
			e.az = arctan2(m10, m00);
		end else begin
			e.ax = arctan2(neg_sat(m12), m11);
			e.az = 0;
		end
		return e;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		angles_seen = 0;
		singular_seen = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		euler_t e;
		if (!arst_n) begin
			threshold <= 15'd1;
		end else begin
			if (psel && penable && pwrite && pready && paddr == {1'b0, RegThreshold})
				threshold <= pwdata[14:0];
			if (start && !busy)
				euler_q.push_back(predict_euler(r00, r10, r11, r12, r20, r21, r22,
					threshold));
			if (done) begin
				if (euler_q.size() == 0) begin
					report_mismatch("unexpected beat", 1, 0);
				end else begin
					e = euler_q.pop_front();
					angles_seen++;
					if (e.sing) singular_seen++;
					if (angle_x !== e.ax) report_mismatch("angle_x", angle_x, e.ax);
					if (angle_y !== e.ay) report_mismatch("angle_y", angle_y, e.ay);
					if (angle_z !== e.az) report_mismatch("angle_z", angle_z, e.az);
					if (singular !== e.sing) report_mismatch("singular", singular, e.sing);
				end
			end
		end
	end
endmodule

>>> tb/rotation_matrix_to_euler_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_top_tb
// drives matrices and threshold settings; the checker predicts and compares
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_top_tb;
	import rme_pkg::*;

	// isqrt stages plus cordic stages plus pipeline overhead, with margin
	localparam int Latency = 4 + 16 + 16 + 2;
	localparam int CycleLimit = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [15:0] r00 = 0, r10 = 0, r11 = 0, r12 = 0, r20 = 0, r21 = 0, r22 = 0;
	logic done, singular, pready;
	logic signed [15:0] angle_x, angle_y, angle_z;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	int fail_count, angles_seen, singular_seen, pending;
	int cycle_count = 0;
	int matrices_sent = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	rotation_matrix_to_euler_top i_dut (.*);

	rme_checker i_checker (.*);

	// watchdog: a hung pipe or a lost beat ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// apb write: setup then access, written on the access edge
	task automatic write_threshold(input logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {1'b0, RegThreshold};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// one matrix beat; start stays high into the next beat, lowered only on a gap or a drain
	task automatic send_matrix(input logic signed [15:0] a, b, c, d, e, f, g);
		r00 <= a; r10 <= b; r11 <= c; r12 <= d; r20 <= e; r21 <= f; r22 <= g;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		matrices_sent++;
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// drain the pipe before touching the register
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (Latency) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_entry(input int mode);
		case (mode)
			0: return 16'($urandom_range(0, 65535));
			1: return $signed(16'($urandom_range(0, 8))) - 16'sd4;
			2: return $urandom_range(0, 1) ? 16'sd16384 - $signed(16'($urandom_range(0, 40)))
				: -16'sd16384 + $signed(16'($urandom_range(0, 40)));
			default: return $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
		endcase
	endfunction

	task automatic random_batch(input int count);
		int mode;
		int ang;
		real c, s;
		for (int k = 0; k < count; k++) begin
			mode = $urandom_range(0, 5);
			if (mode == 5) begin
				// random yaw angle: cos and sin in r00/r10 with random other entries, or near gimbal lock
				ang = $urandom_range(0, 6283);
				c = $cos(ang / 1000.0) * 16384.0;
				s = $sin(ang / 1000.0) * 16384.0;
				if ($urandom_range(0, 3) == 0)
					send_matrix(rand_entry(1), rand_entry(1), 16'(int'(c)), 16'(int'(-s)),
						$urandom_range(0, 1) ? 16'sd16384 : -16'sd16384,
						16'(int'(s)), 16'(int'(c)));
				else
					send_matrix(16'(int'(c)), 16'(int'(s)), 16'(int'(c)), rand_entry(3),
						rand_entry(3), rand_entry(3), rand_entry(3));
			end else begin
				send_matrix(rand_entry(mode % 4), rand_entry(mode % 4), rand_entry(0),
					rand_entry(0), rand_entry(0), rand_entry(0), rand_entry(mode % 4));
			end
			if ($urandom_range(0, 3) == 0) idle_gap();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, both-zero atan2, saturating negation, singular branch
		send_matrix(16'sd16384, 0, 16'sd16384, 0, 0, 0, 16'sd16384);
		send_matrix(0, 0, 0, 0, 0, 0, 0);
		send_matrix(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
			-16'sd32768, -16'sd32768);
		send_matrix(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
			16'sd32767, 16'sd32767);
		send_matrix(0, 0, 16'sd100, -16'sd32768, -16'sd32768, 0, 0);
		send_matrix(-16'sd16384, 0, -16'sd16384, 0, 0, 16'sd5, -16'sd16384);
		send_matrix(-16'sd1, 16'sd1, -16'sd1, 16'sd1, 16'sd1, -16'sd1, -16'sd1);
		send_matrix(0, -16'sd16384, 0, 16'sd32767, 16'sd16384, -16'sd1, 0);
		send_matrix(-16'sd32768, 0, 0, 0, 16'sd16384, 0, -16'sd32768);
		send_matrix(16'sd1, 0, -16'sd32768, 16'sd1, 0, -16'sd16384, 16'sd16384);
		idle_gap();
		random_batch(250);
		drain();

		// threshold extremes and middles, each phase drained first
		write_threshold(32'd0);
		send_matrix(0, 0, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 16'sd7);
		random_batch(350);
		drain();
		write_threshold(32'd32767);
		random_batch(300);
		drain();
		write_threshold(32'd16);
		random_batch(350);
		drain();
		write_threshold(32'd8000);
		random_batch(350);
		drain();
		write_threshold(32'hFFFF_8001);
		random_batch(300);
		drain();

		$display("covered %0d matrices, %0d results, %0d on the gimbal-lock branch",
			matrices_sent, angles_seen, singular_seen);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
